### hdl/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// shared constants for the binary lifting path query block
// ----------------------------------------------------------------------------
package tpq_pkg;
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_DIST   = 2'd1;
  localparam logic [1:0] OP_KTH    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DIST_W = 30;
  localparam int DEPTH_W = 14;
  localparam int POS_W = 15;
endpackage

### hdl/tree_path_query_binary_lifting.sv
// ----------------------------------------------------------------------------
// tree_path_query_binary_lifting
// binary lifting table with distance and kth node path queries
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                        | tuser
// in_     | in  | operation, node_a, node_b, edge_cost, position  | -
// out_    | out | answer[29:0], error[30]                          | -
// a load writes the node's depth, weight and level 0 jump, then fills the higher
// levels; a distance query makes two lifting passes over the levels, and a kth
// query then adds a kth walk down the levels
// reads of the jump and node memories are registered
// reset clears only control state; the memories stay undefined until loaded
// out_tready low holds the result; the next query then waits in its last state
module tree_path_query_binary_lifting #(
  parameter int NODES  = 16384,
  parameter int LEVELS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operation, node_a, node_b, edge_cost, position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // answer, error
);
  localparam int NW = $clog2(NODES);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW = $clog2(LEVELS * NODES);
  localparam int DW = tpq_pkg::DIST_W;
  localparam int EW = tpq_pkg::DEPTH_W;
  localparam int PW = tpq_pkg::POS_W;

  typedef enum logic [4:0] {
    S_IDLE, S_LPAR, S_LPARW, S_LJUMP, S_LJW, S_LMID, S_LMIDW,
    S_QA, S_QAW, S_QB, S_QBW, S_UJ, S_UJW, S_UD, S_UDW,
    S_EQ, S_PJ, S_PJW, S_PV, S_PVW, S_PAR, S_PARW, S_LD, S_LDW,
    S_FIN, S_KJ, S_KJW, S_OUT
  } state_t;

  logic [NW-1:0] jmem [LEVELS*NODES];
  logic [EW-1:0] dmem [NODES];
  logic [DW-1:0] wmem [NODES];

  state_t        st_r;
  logic [1:0]    op_r;
  logic [NW-1:0] a_r, b_r, u_r, v_r, tmp_r;
  logic [15:0]   cost_r;
  logic [PW-1:0] pos_r;
  logic [LW-1:0] lvl_r;
  logic [EW-1:0] da_r, db_r, dv_r, dl_r;
  logic [DW-1:0] wa_r, wb_r, wl_r;
  logic [NW-1:0] jrd_r;
  logic [EW-1:0] drd_r;
  logic [DW-1:0] wrd_r;
  logic          jz_r, nz_r;
  logic          jwe, nwe;
  logic [AW-1:0] jwa, jra;
  logic [LW-1:0] jrl;
  logic [NW-1:0] jrn;
  logic [NW-1:0] jwd, nra;
  logic [NW-1:0] jq;
  logic [EW-1:0] dq;
  logic [DW-1:0] wq;
  logic [EW-1:0] nwd_d;
  logic [DW-1:0] nwd_w;
  logic [15:0]   rem_r;
  logic [31:0]   res_r;
  logic [31:0]   odata_r;
  logic          ovalid_r;
  logic [NW-1:0] ia, ib;

  function automatic logic [NW-1:0] clip(input logic [13:0] v);
    logic [NW-1:0] r;
    r = '0;
    if (32'(v) < NODES) r = NW'(v);
    return r;
  endfunction

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [NW-1:0] n);
    return AW'(32'(l) * NODES + 32'(n));
  endfunction

  assign ia = clip(in_tdata[15:2]);
  assign ib = clip(in_tdata[29:16]);
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // node 0 stands for no node and reads as zero
  assign jra = addr(jrl, jrn);
  assign jq  = jz_r ? '0 : jrd_r;
  assign dq  = nz_r ? '0 : drd_r;
  assign wq  = nz_r ? '0 : wrd_r;

  always_ff @(posedge clk) begin
    if (jwe) jmem[jwa] <= jwd;
    jrd_r <= jmem[jra];
    jz_r <= (jrn == '0);
    if (nwe) begin
      dmem[a_r] <= nwd_d;
      wmem[a_r] <= nwd_w;
    end
    drd_r <= dmem[nra];
    wrd_r <= wmem[nra];
    nz_r <= (nra == '0);
  end

  // combinational memory control
  always_comb begin
    jwe = 1'b0; jwa = addr(lvl_r, a_r); jwd = tmp_r;
    jrl = lvl_r; jrn = u_r; nra = u_r;
    nwe = 1'b0; nwd_d = '0; nwd_w = '0;
    unique case (st_r)
      S_LPARW: begin
        nwe = 1'b1;
        if (b_r != '0) begin
          nwd_d = dq + EW'(1);
          nwd_w = wq + DW'(cost_r);
        end
      end
      S_LJUMP: begin jwe = 1'b1; jwa = addr('0, a_r); jwd = b_r; end
      S_LMID:  begin jrl = lvl_r - LW'(1); jrn = tmp_r; end
      S_LMIDW: begin jwe = 1'b1; jwd = jq; end
      S_QA:    nra = a_r;
      S_QB:    nra = b_r;
      S_UD, S_LD: nra = tmp_r;
      S_PJ:    jrn = v_r;
      S_PAR:   jrl = '0;
      S_KJ:    jrn = tmp_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (st_r == S_OUT && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
      else if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[1:0];
          a_r <= ia; b_r <= ib;
          cost_r <= in_tdata[45:30];
          pos_r <= in_tdata[60:46];
          u_r <= ib;
          if (in_tdata[1:0] == tpq_pkg::OP_LOAD)
            st_r <= (ia == '0) ? S_IDLE : S_LPAR;
          else if (in_tdata[1:0] == tpq_pkg::OP_DIST || in_tdata[1:0] == tpq_pkg::OP_KTH)
            st_r <= S_QA;
        end
        S_LPAR:  st_r <= S_LPARW;
        S_LPARW: begin st_r <= S_LJUMP; tmp_r <= b_r; lvl_r <= LW'(1); end
        S_LJUMP: st_r <= (LEVELS > 1) ? S_LMID : S_IDLE;
        S_LMID:  st_r <= S_LMIDW;
        S_LMIDW: begin
          tmp_r <= jq;
          if (32'(lvl_r) == LEVELS - 1) st_r <= S_IDLE;
          else begin lvl_r <= lvl_r + LW'(1); st_r <= S_LMID; end
        end
        S_QA:  st_r <= S_QAW;
        S_QAW: begin da_r <= dq; wa_r <= wq; st_r <= S_QB; end
        S_QB:  st_r <= S_QBW;
        S_QBW: begin
          db_r <= dq; wb_r <= wq;
          if (da_r < dq) begin
            u_r <= b_r; v_r <= a_r; dv_r <= da_r;
          end else begin
            u_r <= a_r; v_r <= b_r; dv_r <= dq;
          end
          lvl_r <= LW'(LEVELS - 1);
          st_r <= S_UJ;
        end
        S_UJ:  st_r <= S_UJW;
        S_UJW: begin tmp_r <= jq; st_r <= (jq != '0) ? S_UD : S_UDW; end
        S_UD:  st_r <= S_UDW;
        S_UDW: begin
          if (tmp_r != '0 && dq >= dv_r) u_r <= tmp_r;
          if (lvl_r == '0) st_r <= S_EQ;
          else begin lvl_r <= lvl_r - LW'(1); st_r <= S_UJ; end
        end
        S_EQ: begin
          lvl_r <= LW'(LEVELS - 1);
          if (u_r == v_r) begin tmp_r <= u_r; st_r <= S_LD; end
          else st_r <= S_PJ;
        end
        S_PJ:  st_r <= S_PJW;
        S_PJW: begin tmp_r <= jq; st_r <= S_PV; end
        S_PV:  st_r <= S_PVW;
        S_PVW: begin
          if (tmp_r != jq) begin u_r <= jq; v_r <= tmp_r; end
          if (lvl_r == '0) st_r <= S_PAR;
          else begin lvl_r <= lvl_r - LW'(1); st_r <= S_PJ; end
        end
        S_PAR:  st_r <= S_PARW;
        S_PARW: begin tmp_r <= jq; st_r <= S_LD; end
        S_LD:   st_r <= S_LDW;
        S_LDW:  begin dl_r <= dq; wl_r <= wq; st_r <= S_FIN; end
        S_FIN: begin
          if (op_r == tpq_pkg::OP_DIST) begin
            res_r <= {2'b00, wa_r + wb_r - {wl_r[DW-2:0], 1'b0}};
            st_r <= S_OUT;
          end else begin
            logic signed [16:0] lf, rt, tot, pc;
            lf = $signed({3'b000, da_r}) - $signed({3'b000, dl_r}) + 17'sd1;
            rt = $signed({3'b000, db_r}) - $signed({3'b000, dl_r}) + 17'sd1;
            tot = lf + rt - 17'sd1;
            pc = $signed({2'b00, pos_r});
            if (pc < 17'sd1 || pc > tot) begin
              res_r <= {1'b0, 1'b1, 30'd0};
              st_r <= S_OUT;
            end else begin
              if (pc > lf) begin
                rem_r <= 16'(lf + rt - pc - 17'sd1);
                tmp_r <= b_r;
              end else begin
                rem_r <= 16'(pc - 17'sd1);
                tmp_r <= a_r;
              end
              lvl_r <= LW'(LEVELS - 1);
              st_r <= S_KJ;
            end
          end
        end
        S_KJ: begin
          if (32'(lvl_r) < 16 && (16'd1 << lvl_r) <= rem_r) begin
            rem_r <= rem_r - (16'd1 << lvl_r);
            st_r <= S_KJW;
          end else if (lvl_r == '0) begin
            res_r <= {2'b00, 30'(tmp_r)};
            st_r <= S_OUT;
          end else lvl_r <= lvl_r - LW'(1);
        end
        S_KJW: begin
          tmp_r <= jq;
          if (lvl_r == '0) begin
            res_r <= {2'b00, 30'(jq)};
            st_r <= S_OUT;
          end else begin
            lvl_r <= lvl_r - LW'(1);
            st_r <= S_KJ;
          end
        end
        S_OUT: if (!ovalid_r || out_tready) begin odata_r <= res_r; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives tree loads and path queries into the binary lifting block, predicts
// each distance and kth node answer from a private copy of the tree, and
// checks every result transfer in order
// ----------------------------------------------------------------------------
class path_scoreboard;
  bit [13:0] anc[14][16384];
  bit [13:0] lvl[16384];
  bit [29:0] wsum[16384];
  bit [30:0] expect_q[$];
  int        fails;

  function bit [13:0] meet_node(bit [13:0] u, bit [13:0] v);
    bit [13:0] t;
    bit [13:0] w;
    if (lvl[u] < lvl[v]) begin
      t = u;
      u = v;
      v = t;
    end
    for (int i = 13; i >= 0; i--) begin
      w = anc[i][u];
      if (w != 0 && lvl[w] >= lvl[v]) u = w;
    end
    if (u == v) return u;
    for (int i = 13; i >= 0; i--) begin
      if (anc[i][u] != anc[i][v]) begin
        u = anc[i][u];
        v = anc[i][v];
      end
    end
    return anc[0][u];
  endfunction

  function int path_len(bit [13:0] a, bit [13:0] b);
    bit [13:0] m;
    m = meet_node(a, b);
    return int'(lvl[a]) + int'(lvl[b]) - 2 * int'(lvl[m]) + 1;
  endfunction

  function void note_transfer(bit [1:0] op, bit [13:0] a, bit [13:0] b,
                              bit [15:0] cost, bit [14:0] pos);
    bit [13:0] m;
    bit [29:0] d;
    int left, right, c, rem;
    if (op == tpq_pkg::OP_LOAD) begin
      if (a == 0) return;
      if (b == 0) begin
        lvl[a] = 0;
        wsum[a] = 0;
      end else begin
        lvl[a] = lvl[b] + 14'd1;
        wsum[a] = wsum[b] + 30'(cost);
      end
      anc[0][a] = b;
      for (int i = 1; i < 14; i++) anc[i][a] = anc[i-1][anc[i-1][a]];
    end else if (op == tpq_pkg::OP_DIST) begin
      m = meet_node(a, b);
      d = wsum[a] + wsum[b] - 30'(2 * wsum[m]);
      expect_q.push_back({1'b0, d});
    end else if (op == tpq_pkg::OP_KTH) begin
      m = meet_node(a, b);
      left = int'(lvl[a]) - int'(lvl[m]) + 1;
      right = int'(lvl[b]) - int'(lvl[m]) + 1;
      c = int'(pos);
      if (c < 1 || c > left + right - 1) begin
        expect_q.push_back({1'b1, 30'd0});
        return;
      end
      if (c > left) begin
        c = left + right - c;
        a = b;
      end
      rem = c - 1;
      for (int i = 13; i >= 0; i--) begin
        if ((1 << i) <= rem) begin
          a = anc[i][a];
          rem -= (1 << i);
        end
      end
      expect_q.push_back({1'b0, 16'd0, a});
    end
  endfunction

  function void check_result(bit [29:0] answer, bit err);
    bit [30:0] exp_v;
    if (expect_q.size() == 0) begin
      $display("%0t: unexpected result answer=%0d error=%0d", $time, answer, err);
      fails++;
      return;
    end
    exp_v = expect_q.pop_front();
    if (exp_v[29:0] !== answer) begin
      $display("%0t: answer mismatch expected=%0d actual=%0d", $time, exp_v[29:0], answer);
      fails++;
    end
    if (exp_v[30] !== err) begin
      $display("%0t: error mismatch expected=%0d actual=%0d", $time, exp_v[30], err);
      fails++;
    end
  endfunction
endclass

module tb_top;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  path_scoreboard sb = new();
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;
  bit        hold_seen = 1'b0;
  int        hold_left = 0;
  bit        used[16384];
  int        parent_of[16384];
  int        loaded[$];

  tree_path_query_binary_lifting u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  task automatic send_item(bit [1:0] op, bit [13:0] a, bit [13:0] b,
                           bit [15:0] cost, bit [14:0] pos);
    in_tdata <= {3'b0, pos, cost, b, a, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(op, a, b, cost, pos);
    if (idle_on && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_node(int n, int p, bit [15:0] cost);
    send_item(tpq_pkg::OP_LOAD, 14'(n), 14'(p), cost, 15'($urandom));
    if (!used[n]) loaded.push_back(n);
    used[n] = 1'b1;
    parent_of[n] = p;
  endtask

  task automatic load_fresh();
    int n;
    int p;
    do n = $urandom_range(1, 16383); while (used[n]);
    p = ($urandom_range(99) < 60) ? loaded[$] : loaded[$urandom_range(loaded.size() - 1)];
    load_node(n, p, 16'($urandom));
  endtask

  task automatic ask_kth(int a, int b);
    int total;
    int pos;
    total = sb.path_len(14'(a), 14'(b));
    case ($urandom_range(9))
      0: pos = 0;
      1: pos = $urandom_range(32767);
      2: pos = total + $urandom_range(1, 3);
      default: pos = $urandom_range(1, total);
    endcase
    send_item(tpq_pkg::OP_KTH, 14'(a), 14'(b), 16'($urandom), 15'(pos));
  endtask

  // result side with random stalls and a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata[29:0], out_tdata[30]);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 12);
      end
    end
  end

  initial begin
    int a, b, r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: chain from a root, extremes, ignored items, edge positions
    load_node(1, 0, 16'd0);
    load_node(16383, 1, 16'hffff);
    load_node(8192, 16383, 16'hffff);
    load_node(5461, 8192, 16'd0);
    load_node(10922, 1, 16'd7);
    send_item(tpq_pkg::OP_LOAD, 0, 1, 16'h1234, 0);
    send_item(tpq_pkg::OP_UNUSED, 16383, 16383, 16'hffff, 15'h7fff);
    send_item(tpq_pkg::OP_DIST, 16383, 16383, 0, 0);
    send_item(tpq_pkg::OP_DIST, 5461, 10922, 0, 0);
    send_item(tpq_pkg::OP_DIST, 1, 8192, 0, 0);
    send_item(tpq_pkg::OP_KTH, 5461, 10922, 0, 0);
    send_item(tpq_pkg::OP_KTH, 5461, 10922, 0, 1);
    send_item(tpq_pkg::OP_KTH, 5461, 10922, 0, 3);
    send_item(tpq_pkg::OP_KTH, 5461, 10922, 0, 5);
    send_item(tpq_pkg::OP_KTH, 5461, 10922, 0, 6);
    send_item(tpq_pkg::OP_KTH, 5461, 10922, 0, 15'h7fff);
    send_item(tpq_pkg::OP_KTH, 1, 1, 0, 1);
    load_node(8192, 16383, 16'h00ff);
    send_item(tpq_pkg::OP_DIST, 5461, 1, 0, 0);
    load_node(1, 0, 16'h5555);
    send_item(tpq_pkg::OP_KTH, 10922, 5461, 0, 2);

    for (int k = 0; k < 1430; k++) begin
      if (k == 400) hold_req = 1'b1;
      if (k == 800) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expect_q.size() != 0) @(posedge clk);
      end
      idle_on = !(k >= 900 && k < 1100);
      a = loaded[$urandom_range(loaded.size() - 1)];
      b = loaded[$urandom_range(loaded.size() - 1)];
      if ($urandom_range(9) == 0) b = (parent_of[a] != 0) ? parent_of[a] : a;
      else if ($urandom_range(19) == 0) b = a;
      r = $urandom_range(99);
      if (r < 4) begin
        if ($urandom_range(1))
          send_item(tpq_pkg::OP_UNUSED, 14'($urandom), 14'($urandom), 16'($urandom),
                    15'($urandom));
        else send_item(tpq_pkg::OP_LOAD, 0, 14'(a), 16'($urandom), 15'($urandom));
      end else if (r < 8) begin
        load_node(a, parent_of[a], 16'($urandom));
      end else if (r < 40) begin
        load_fresh();
      end else if (r < 70) begin
        send_item(tpq_pkg::OP_DIST, 14'(a), 14'(b), 16'($urandom), 15'($urandom));
      end else begin
        ask_kth(a, b);
      end
    end
    in_tvalid <= 1'b0;
    idle_on = 1'b1;
    while (sb.expect_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.fails == 0 && sb.expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

### tree_path_query_binary_lifting.f
hdl/tpq_pkg.sv
hdl/tree_path_query_binary_lifting.sv
tb/tb_top.sv
